/* hw/rtl/cctm_pkg.sv */
// ----------------------------------------------------------------------------
// cctm_pkg
// Shared types and codes of the compare channel timer multiplexer: request
// and result codes, data widths and the shared arithmetic unit's interface.
// ----------------------------------------------------------------------------
`default_nettype none

package cctm_pkg;

   localparam int DATA_W = 32;
   localparam int LEAD_W = 16;
   localparam int KIND_W = 2;
   localparam int REQ_W  = 2;
   localparam int SLOT_W = 3;

   localparam logic [DATA_W-1:0] PERIOD_MAX = 32'hFFFF_FFFE;
   localparam logic [DATA_W-1:0] ALL_ONES   = 32'hFFFF_FFFF;
   localparam logic [LEAD_W-1:0] MIN_LEAD_RESET = 16'd2;

   // request codes
   localparam logic [REQ_W-1:0] REQ_ARM    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_DISARM = 2'd1;
   localparam logic [REQ_W-1:0] REQ_EVENT  = 2'd2;

   // result codes
   localparam logic [KIND_W-1:0] KIND_SET     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NOTICE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DISABLE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;

   typedef struct packed {
      logic [DATA_W-1:0] op_a;
      logic [DATA_W-1:0] op_b;
      logic              sub;
      logic [LEAD_W-1:0] min_lead;
      logic [DATA_W-1:0] best;
   } alu_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] res;
      logic              lt_lead;
      logic              le_lead;
      logic              lt_best;
   } alu_rsp_type;

endpackage

`default_nettype wire

/* hw/rtl/compare_channel_timer_multiplexer.sv */
// ----------------------------------------------------------------------------
// compare_channel_timer_multiplexer
// Multiplexes NUM_TIMERS one-shot or continuous timers onto one compare
// channel of a free-running 32-bit counter.
// ----------------------------------------------------------------------------
// An arm or compare event walks every slot through one shared adder: first the
// elapsed-tick subtract setup, then each idle or finished slot in ST_WALK_A
// alone and each live slot in ST_WALK_A then ST_WALK_B, then for an arm the
// period compare, and last, for an arm or when any slot is live, the forming
// of the compare value. A compare event then scans the slots for notices, one
// slot a cycle unless a notice waits for the result channel. A disarm or
// ignored request gives a single result. The block is busy (req_ready low)
// until it writes its final result; that result sits in the output register
// and the next request is taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module compare_channel_timer_multiplexer #(
   parameter int NUM_TIMERS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [cctm_pkg::LEAD_W-1:0]     csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [cctm_pkg::REQ_W-1:0]      req_type,
   input  logic [cctm_pkg::SLOT_W-1:0]     req_slot,
   input  logic [cctm_pkg::DATA_W-1:0]     req_period,
   input  logic                            req_continuous,
   input  logic [cctm_pkg::DATA_W-1:0]     req_now_count,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [cctm_pkg::KIND_W-1:0]     rsp_kind,
   output logic [cctm_pkg::SLOT_W-1:0]     rsp_notice_slot,
   output logic [cctm_pkg::DATA_W-1:0]     rsp_compare_value,
   output logic                            rsp_last
);
   import cctm_pkg::*;

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_DELTA   = 8'b0000_0010,
      ST_WALK_A  = 8'b0000_0100,
      ST_WALK_B  = 8'b0000_1000,
      ST_LEAD    = 8'b0001_0000,
      ST_COMPARE = 8'b0010_0000,
      ST_NOTICE  = 8'b0100_0000,
      ST_SINGLE  = 8'b1000_0000
   } state_type;

   // control state
   state_type               state_ff, state_in;
   logic [LEAD_W-1:0]       min_lead_ff, min_lead_in;
   logic [NUM_TIMERS-1:0]   active_ff, active_in;
   logic [NUM_TIMERS-1:0]   expired_ff, expired_in;
   logic [NUM_TIMERS-1:0]   done_ff, done_in;
   logic [DATA_W-1:0]       last_count_ff, last_count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    any_ff, any_in;

   // slot storage, written before it is read
   logic [DATA_W-1:0]       period_ff [NUM_TIMERS];
   logic [DATA_W-1:0]       period_in [NUM_TIMERS];
   logic [DATA_W-1:0]       remaining_ff [NUM_TIMERS];
   logic [DATA_W-1:0]       remaining_in [NUM_TIMERS];
   logic [NUM_TIMERS-1:0]   repeat_ff, repeat_in;

   // request and work registers
   logic [REQ_W-1:0]        type_ff, type_in;
   logic [IDX_W-1:0]        slot_ff, slot_in;
   logic [DATA_W-1:0]       per_ff, per_in;
   logic [DATA_W-1:0]       now_ff, now_in;
   logic [DATA_W-1:0]       delta_ff, delta_in;
   logic [DATA_W-1:0]       diff_ff, diff_in;
   logic                    below_ff, below_in;
   logic [DATA_W-1:0]       best_ff, best_in;
   logic [KIND_W-1:0]       kind_pend_ff, kind_pend_in;

   // result register
   logic [KIND_W-1:0]       rsp_kind_ff, rsp_kind_in;
   logic [SLOT_W-1:0]       rsp_slot_ff, rsp_slot_in;
   logic [DATA_W-1:0]       rsp_cmp_ff, rsp_cmp_in;
   logic                    rsp_last_ff, rsp_last_in;

   alu_req_type             alu_req;
   alu_rsp_type             alu_rsp;

   logic [NUM_TIMERS-1:0]   pending;
   logic [NUM_TIMERS-1:0]   pending_above;
   logic [NUM_TIMERS-1:0]   others_active;
   logic [IDX_W-1:0]        req_idx;
   logic                    slot_ok;
   logic [DATA_W-1:0]       per_sat;
   logic                    out_free;
   logic                    idx_last;
   logic                    part;
   logic                    is_arm;
   logic                    arm_slot;

   cctm_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign req_idx  = IDX_W'(req_slot);
   assign slot_ok  = 32'(req_slot) < 32'(NUM_TIMERS);
   assign per_sat  = (req_period == ALL_ONES) ? PERIOD_MAX : req_period;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign idx_last = idx_ff == IDX_W'(NUM_TIMERS - 1);
   assign is_arm   = type_ff == REQ_ARM;
   assign arm_slot = is_arm && (idx_ff == slot_ff);
   // a one-shot slot that has expired sits out the update
   assign part     = active_ff[idx_ff] && !(expired_ff[idx_ff] && !repeat_ff[idx_ff]);

   always_comb begin
      for (int j = 0; j < NUM_TIMERS; j++) begin
         pending[j]       = active_ff[j] && expired_ff[j] && (repeat_ff[j] || !done_ff[j]);
         pending_above[j] = pending[j] && (IDX_W'(j) > idx_ff);
         others_active[j] = active_ff[j] && (IDX_W'(j) != req_idx);
      end
   end

   // operand selection for the shared unit
   always_comb begin
      alu_req.op_a     = '0;
      alu_req.op_b     = '0;
      alu_req.sub      = 1'b0;
      alu_req.min_lead = min_lead_ff;
      alu_req.best     = best_ff;
      unique case (state_ff)
         ST_DELTA: begin
            alu_req.op_a = now_ff;
            alu_req.op_b = last_count_ff;
            alu_req.sub  = 1'b1;
         end
         ST_WALK_A: begin
            alu_req.op_a = remaining_ff[idx_ff];
            alu_req.op_b = delta_ff;
            alu_req.sub  = 1'b1;
         end
         ST_WALK_B: begin
            alu_req.op_a = diff_ff;
            alu_req.op_b = (below_ff && repeat_ff[idx_ff]) ? period_ff[idx_ff] : '0;
         end
         ST_LEAD: begin
            alu_req.op_a = per_ff;
         end
         ST_COMPARE: begin
            alu_req.op_a = now_ff;
            alu_req.op_b = best_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      min_lead_in   = min_lead_ff;
      active_in     = active_ff;
      expired_in    = expired_ff;
      done_in       = done_ff;
      last_count_in = last_count_ff;
      rsp_valid_in  = rsp_valid_ff;
      idx_in        = idx_ff;
      any_in        = any_ff;
      period_in     = period_ff;
      remaining_in  = remaining_ff;
      repeat_in     = repeat_ff;
      type_in       = type_ff;
      slot_in       = slot_ff;
      per_in        = per_ff;
      now_in        = now_ff;
      delta_in      = delta_ff;
      diff_in       = diff_ff;
      below_in      = below_ff;
      best_in       = best_ff;
      kind_pend_in  = kind_pend_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_cmp_in    = rsp_cmp_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_we) begin
         min_lead_in = csr_wdata;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               type_in = req_type;
               slot_in = req_idx;
               per_in  = per_sat;
               now_in  = req_now_count;
               if (req_type == REQ_ARM && slot_ok) begin
                  // load the slot first so a re-armed slot updates with its new values
                  repeat_in[req_idx]    = req_continuous;
                  period_in[req_idx]    = per_sat;
                  remaining_in[req_idx] = per_sat;
                  expired_in[req_idx]   = 1'b0;
                  done_in[req_idx]      = 1'b0;
                  state_in              = ST_DELTA;
               end else if (req_type == REQ_DISARM && slot_ok && active_ff[req_idx]) begin
                  active_in[req_idx]  = 1'b0;
                  expired_in[req_idx] = 1'b0;
                  done_in[req_idx]    = 1'b0;
                  kind_pend_in        = (|others_active) ? KIND_NONE : KIND_DISABLE;
                  state_in            = ST_SINGLE;
               end else if (req_type == REQ_EVENT) begin
                  state_in = ST_DELTA;
               end else begin
                  kind_pend_in = KIND_NONE;
                  state_in     = ST_SINGLE;
               end
            end
         end

         ST_DELTA: begin
            delta_in      = alu_rsp.res;
            last_count_in = now_ff;
            idx_in        = '0;
            best_in       = ALL_ONES;
            any_in        = 1'b0;
            state_in      = ST_WALK_A;
         end

         ST_WALK_A, ST_WALK_B: begin
            if (state_ff == ST_WALK_A && part) begin
               diff_in  = alu_rsp.res;
               below_in = alu_rsp.lt_lead;
               state_in = ST_WALK_B;
            end else begin
               if (state_ff == ST_WALK_B) begin
                  // the slot being armed keeps its fresh count but still sets the lead
                  remaining_in[idx_ff] = arm_slot ? per_ff : alu_rsp.res;
                  if (below_ff && !arm_slot) begin
                     expired_in[idx_ff] = 1'b1;
                  end
                  any_in = 1'b1;
                  if (alu_rsp.le_lead) begin
                     best_in = DATA_W'(min_lead_ff);
                  end else if (alu_rsp.lt_best) begin
                     best_in = alu_rsp.res;
                  end
               end
               if (!idx_last) begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_WALK_A;
               end else if (is_arm) begin
                  state_in = ST_LEAD;
               end else if (any_in) begin
                  state_in = ST_COMPARE;
               end else if (|pending) begin
                  idx_in   = '0;
                  state_in = ST_NOTICE;
               end else begin
                  kind_pend_in = KIND_NONE;
                  state_in     = ST_SINGLE;
               end
            end
         end

         ST_LEAD: begin
            active_in[slot_ff] = 1'b1;
            if (alu_rsp.lt_best) begin
               best_in = per_ff;
            end
            state_in = ST_COMPARE;
         end

         ST_COMPARE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_SET;
               rsp_slot_in  = '0;
               rsp_cmp_in   = alu_rsp.res;
               // expiries found during an arm wait for the next compare event
               rsp_last_in  = is_arm || !(|pending);
               if (is_arm || !(|pending)) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = '0;
                  state_in = ST_NOTICE;
               end
            end
         end

         ST_NOTICE: begin
            if (pending[idx_ff]) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_NOTICE;
                  rsp_slot_in  = SLOT_W'(idx_ff);
                  rsp_cmp_in   = '0;
                  rsp_last_in  = !(|pending_above);
                  if (repeat_ff[idx_ff]) begin
                     expired_in[idx_ff] = 1'b0;
                  end else begin
                     done_in[idx_ff] = 1'b1;
                  end
                  if (!(|pending_above) || idx_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
            end else if (idx_last) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_SINGLE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_pend_ff;
               rsp_slot_in  = '0;
               rsp_cmp_in   = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         min_lead_ff   <= MIN_LEAD_RESET;
         active_ff     <= '0;
         expired_ff    <= '0;
         done_ff       <= '0;
         last_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         idx_ff        <= '0;
         any_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         min_lead_ff   <= min_lead_in;
         active_ff     <= active_in;
         expired_ff    <= expired_in;
         done_ff       <= done_in;
         last_count_ff <= last_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         idx_ff        <= idx_in;
         any_ff        <= any_in;
      end
   end

   always_ff @(posedge clock) begin
      period_ff    <= period_in;
      remaining_ff <= remaining_in;
      repeat_ff    <= repeat_in;
      type_ff      <= type_in;
      slot_ff      <= slot_in;
      per_ff       <= per_in;
      now_ff       <= now_in;
      delta_ff     <= delta_in;
      diff_ff      <= diff_in;
      below_ff     <= below_in;
      best_ff      <= best_in;
      kind_pend_ff <= kind_pend_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_cmp_ff   <= rsp_cmp_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_ready         = state_ff == ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_notice_slot   = rsp_slot_ff;
   assign rsp_compare_value = rsp_cmp_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

`default_nettype wire

/* hw/rtl/cctm_alu.sv */
// ----------------------------------------------------------------------------
// cctm_alu
// Shared add/subtract unit with the lead and best-lead compares on its sum.
// ----------------------------------------------------------------------------
`default_nettype none

module cctm_alu (
   input  cctm_pkg::alu_req_type alu_req,
   output cctm_pkg::alu_rsp_type alu_rsp
);
   import cctm_pkg::*;

   logic [DATA_W-1:0] sum;
   logic [DATA_W-1:0] lead_ext;

   assign lead_ext = DATA_W'(alu_req.min_lead);
   assign sum      = alu_req.sub ? (alu_req.op_a - alu_req.op_b)
                                 : (alu_req.op_a + alu_req.op_b);

   // sum read as signed: negative always counts as under the lead
   assign alu_rsp.res     = sum;
   assign alu_rsp.lt_lead = sum[DATA_W-1] || (sum < lead_ext);
   assign alu_rsp.le_lead = sum[DATA_W-1] || (sum <= lead_ext);
   assign alu_rsp.lt_best = sum < alu_req.best;

endmodule

`default_nettype wire

/* hw/rtl/cctm_checker.sv */
// ----------------------------------------------------------------------------
// cctm_checker
// Port-level checks of the compare channel timer multiplexer, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cctm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [cctm_pkg::KIND_W-1:0]     rsp_kind,
   input logic [cctm_pkg::SLOT_W-1:0]     rsp_notice_slot,
   input logic [cctm_pkg::DATA_W-1:0]     rsp_compare_value,
   input logic                            rsp_last
);
   import cctm_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_notice_slot) && $stable(rsp_compare_value) && $stable(rsp_last))
      else $error("result changed while stalled");

   // the block is busy in the cycle after it takes a request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken back to back");

   a_cmp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_SET |-> rsp_compare_value == '0)
      else $error("compare value on a non-compare result");

   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_NOTICE |-> rsp_notice_slot == '0)
      else $error("slot on a non-notice result");

   // disable and no-change results always close their request
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_DISABLE || rsp_kind == KIND_NONE) |-> rsp_last)
      else $error("single result not marked last");

endmodule

bind compare_channel_timer_multiplexer cctm_checker u_cctm_checker (.*);

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the compare channel timer multiplexer. Requests go
// in over a valid/ready channel and are mirrored in a cycle-free predictor of
// the slot table. Every result transfer is checked in order against the
// predicted results. The run covers ignored requests, timer lifecycles and
// random traffic under several lead settings with sender and receiver idling.
// ----------------------------------------------------------------------------

module testbench;
   import cctm_pkg::*;

   localparam int SLOTS = 8;
   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 40;

   // request code the block ignores
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [SLOT_W-1:0] slot;
      logic [DATA_W-1:0] cmp;
      logic              last;
   } rsp_item_type;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [LEAD_W-1:0]   csr_wdata;
   logic                req_valid;
   logic                req_ready;
   logic [REQ_W-1:0]    req_type;
   logic [SLOT_W-1:0]   req_slot;
   logic [DATA_W-1:0]   req_period;
   logic                req_continuous;
   logic [DATA_W-1:0]   req_now_count;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [KIND_W-1:0]   rsp_kind;
   logic [SLOT_W-1:0]   rsp_notice_slot;
   logic [DATA_W-1:0]   rsp_compare_value;
   logic                rsp_last;

   // predicted slot table
   logic [LEAD_W-1:0]   lead_cfg;
   bit                  armed [SLOTS];
   bit                  cont_q [SLOTS];
   bit                  fired [SLOTS];
   bit                  notified [SLOTS];
   logic [DATA_W-1:0]   per_q [SLOTS];
   logic [DATA_W-1:0]   left_q [SLOTS];
   logic [DATA_W-1:0]   last_now;

   rsp_item_type        due_responses [$];
   int                  errors;
   int                  quiet_cycles;
   int                  sender_idle_pct;
   int                  stall_pct;
   logic [DATA_W-1:0]   tick_now;

   compare_channel_timer_multiplexer #(.NUM_TIMERS(SLOTS)) dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_slot          (req_slot),
      .req_period        (req_period),
      .req_continuous    (req_continuous),
      .req_now_count     (req_now_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_notice_slot   (rsp_notice_slot),
      .rsp_compare_value (rsp_compare_value),
      .rsp_last          (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic rsp_item_type make_resp(logic [KIND_W-1:0] kind,
                                              logic [SLOT_W-1:0] slot,
                                              logic [DATA_W-1:0] cmp);
      rsp_item_type r;
      r.kind = kind;
      r.slot = slot;
      r.cmp  = cmp;
      r.last = 1'b0;
      return r;
   endfunction

   // Subtract the elapsed ticks from every live slot, flag expiries and
   // reload continuous slots; give the next lead.
   function automatic void age_slots(input logic [DATA_W-1:0] now, output bit any,
                                     output logic [DATA_W-1:0] lead);
      logic [DATA_W-1:0] delta;
      logic [DATA_W-1:0] best;
      logic [DATA_W-1:0] r;
      logic [DATA_W-1:0] thr;
      delta = now - last_now;
      best = ALL_ONES;
      thr = {16'd0, lead_cfg};
      any = 1'b0;
      last_now = now;
      for (int i = 0; i < SLOTS; i++) begin
         if (!armed[i] || (fired[i] && !cont_q[i])) continue;
         r = left_q[i] - delta;
         if (r[31] || r < thr) begin
            fired[i] = 1'b1;
            if (cont_q[i]) r = r + per_q[i];
         end
         left_q[i] = r;
         any = 1'b1;
         if (r[31] || r <= thr) best = thr;
         else if (r < best) best = r;
      end
      lead = best;
   endfunction

   function automatic void compute_responses(logic [REQ_W-1:0] rq, logic [SLOT_W-1:0] s,
                                             logic [DATA_W-1:0] per, logic c,
                                             logic [DATA_W-1:0] now);
      rsp_item_type batch [$];
      logic [DATA_W-1:0] p;
      logic [DATA_W-1:0] lead;
      bit any;
      if (rq == REQ_ARM) begin
         p = (per > PERIOD_MAX) ? PERIOD_MAX : per;
         cont_q[s] = c;
         per_q[s] = p;
         left_q[s] = p;
         fired[s] = 1'b0;
         notified[s] = 1'b0;
         age_slots(now, any, lead);
         if (!any) lead = ALL_ONES;
         armed[s] = 1'b1;
         left_q[s] = p;
         fired[s] = 1'b0;
         notified[s] = 1'b0;
         if (p < lead) lead = p;
         batch.insert(batch.size(), make_resp(KIND_SET, '0, now + lead));
      end else if (rq == REQ_DISARM && armed[s]) begin
         armed[s] = 1'b0;
         fired[s] = 1'b0;
         notified[s] = 1'b0;
         any = 1'b0;
         for (int i = 0; i < SLOTS; i++) if (armed[i]) any = 1'b1;
         batch.insert(batch.size(), make_resp(any ? KIND_NONE : KIND_DISABLE, '0, '0));
      end else if (rq == REQ_EVENT) begin
         age_slots(now, any, lead);
         if (any) batch.insert(batch.size(), make_resp(KIND_SET, '0, now + lead));
         for (int i = 0; i < SLOTS; i++) begin
            if (!armed[i] || !fired[i]) continue;
            if (cont_q[i]) begin
               fired[i] = 1'b0;
               batch.insert(batch.size(), make_resp(KIND_NOTICE, i[SLOT_W-1:0], '0));
            end else if (!notified[i]) begin
               notified[i] = 1'b1;
               batch.insert(batch.size(), make_resp(KIND_NOTICE, i[SLOT_W-1:0], '0));
            end
         end
         if (batch.size() == 0) batch.insert(0, make_resp(KIND_NONE, '0, '0));
      end else begin
         batch.insert(0, make_resp(KIND_NONE, '0, '0));
      end
      batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) due_responses.insert(due_responses.size(), batch[i]);
   endfunction

   // Check every result transfer against the oldest prediction.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_responses.size() == 0) begin
            errors++;
            $display("%0t: unexpected result kind=%0d slot=%0d cmp=%h last=%0d", $time,
                     rsp_kind, rsp_notice_slot, rsp_compare_value, rsp_last);
         end else begin
            want = due_responses.pop_front();
            if (rsp_kind !== want.kind || rsp_notice_slot !== want.slot ||
                rsp_compare_value !== want.cmp || rsp_last !== want.last) begin
               errors++;
               $display("%0t: expected kind=%0d slot=%0d cmp=%h last=%0d,",
                        $time, want.kind, want.slot, want.cmp, want.last,
                        " got kind=%0d slot=%0d cmp=%h last=%0d",
                        rsp_kind, rsp_notice_slot, rsp_compare_value, rsp_last);
            end
         end
      end
   end

   // Stall the result channel at the current rate.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // End the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_req(logic [REQ_W-1:0] rq, logic [SLOT_W-1:0] s,
                           logic [DATA_W-1:0] per, logic c, logic [DATA_W-1:0] now);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= rq;
      req_slot <= s;
      req_period <= per;
      req_continuous <= c;
      req_now_count <= now;
      do @(posedge clock); while (!req_ready);
      compute_responses(rq, s, per, c, now);
   endtask

   // Hold the sender until every predicted result has been transferred.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_responses.size() != 0) @(posedge clock);
   endtask

   task automatic write_min_lead(logic [LEAD_W-1:0] value);
      drain_results();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      lead_cfg = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic test_ignored_requests();
      send_req(REQ_EVENT, 3'd0, 32'd0, 1'b0, 32'd0);
      send_req(REQ_DISARM, 3'd5, 32'd0, 1'b0, 32'd0);
      send_req(REQ_UNUSED, 3'd7, ALL_ONES, 1'b1, ALL_ONES);
   endtask

   task automatic test_timer_lifecycle();
      send_req(REQ_ARM, 3'd0, 32'd100, 1'b0, 32'd10);
      send_req(REQ_ARM, 3'd7, ALL_ONES, 1'b1, 32'd20);     // saturated period
      send_req(REQ_ARM, 3'd1, 32'd0, 1'b0, 32'd20);
      send_req(REQ_EVENT, 3'd0, 32'd0, 1'b0, 32'd30);
      send_req(REQ_EVENT, 3'd0, 32'd0, 1'b0, 32'd150);      // one-shot expires
      send_req(REQ_EVENT, 3'd0, 32'd0, 1'b0, 32'd200);      // no second notice
      send_req(REQ_ARM, 3'd2, 32'd50, 1'b1, 32'd210);
      send_req(REQ_EVENT, 3'd0, 32'd0, 1'b0, 32'd270);      // continuous reload
      send_req(REQ_EVENT, 3'd0, 32'd0, 1'b0, 32'd400);
      send_req(REQ_ARM, 3'd2, 32'd30, 1'b0, 32'd405);       // re-arm live slot
      send_req(REQ_EVENT, 3'd0, 32'd0, 1'b0, 32'hFFFF_FFF0);
      send_req(REQ_EVENT, 3'd0, 32'd0, 1'b0, 32'd5);        // counter wrap
      send_req(REQ_DISARM, 3'd0, 32'd0, 1'b0, 32'd6);
      send_req(REQ_DISARM, 3'd1, 32'd0, 1'b0, 32'd6);
      send_req(REQ_DISARM, 3'd2, 32'd0, 1'b0, 32'd6);
      send_req(REQ_DISARM, 3'd7, 32'd0, 1'b0, 32'd6);       // last one: disable
      send_req(REQ_ARM, 3'd3, PERIOD_MAX, 1'b1, ALL_ONES);
      send_req(REQ_ARM, 3'd4, 32'd1, 1'b0, 32'd0);
      send_req(REQ_EVENT, 3'd0, 32'd0, 1'b0, 32'd3);
      send_req(REQ_DISARM, 3'd3, 32'd0, 1'b0, 32'd4);
      send_req(REQ_DISARM, 3'd4, 32'd0, 1'b0, 32'd4);
   endtask

   task automatic test_random_traffic(logic [LEAD_W-1:0] lead, int idle, int stall, int count);
      int pick;
      logic [REQ_W-1:0] rq;
      logic [DATA_W-1:0] per;
      int span;
      write_min_lead(lead);
      sender_idle_pct = idle;
      stall_pct = stall;
      span = 4 * lead + 800;
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) drain_results();
         pick = $urandom_range(0, 99);
         rq = (pick < 40) ? REQ_ARM : (pick < 55) ? REQ_DISARM :
              (pick < 95) ? REQ_EVENT : REQ_UNUSED;
         pick = $urandom_range(0, 99);
         if (pick < 85) per = $urandom_range(0, span);
         else if (pick < 95) per = $urandom;
         else if (pick < 97) per = 32'd0;
         else per = (pick == 97) ? PERIOD_MAX : ALL_ONES;
         if ($urandom_range(0, 9) == 0) tick_now = $urandom;
         else tick_now = tick_now + $urandom_range(0, span / 2);
         send_req(rq, SLOT_W'($urandom_range(0, SLOTS - 1)), per,
                  1'($urandom_range(0, 1)), tick_now);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_type = '0;
      req_slot = '0;
      req_period = '0;
      req_continuous = 1'b0;
      req_now_count = '0;
      rsp_ready = 1'b0;
      errors = 0;
      quiet_cycles = 0;
      sender_idle_pct = 0;
      stall_pct = 0;
      tick_now = '0;
      lead_cfg = MIN_LEAD_RESET;
      last_now = '0;
      for (int i = 0; i < SLOTS; i++) begin
         armed[i] = 1'b0;
         cont_q[i] = 1'b0;
         fired[i] = 1'b0;
         notified[i] = 1'b0;
         per_q[i] = '0;
         left_q[i] = '0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_ignored_requests();
      test_timer_lifecycle();
      test_random_traffic(16'd0, 0, 0, 60);
      test_random_traffic(16'hFFFF, 70, 0, 55);
      test_random_traffic(LEAD_W'($urandom_range(1, 200)), 0, 70, 60);
      test_random_traffic(MIN_LEAD_RESET, 35, 35, 60);

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/cctm_pkg.sv
hw/rtl/cctm_alu.sv
hw/rtl/compare_channel_timer_multiplexer.sv
hw/rtl/cctm_checker.sv
bench/testbench.sv
